[rtl/mls_pkg.sv]
//------------------------------------------------------------------------------
// mls_pkg
// shared types and constants for the lid sequencer
//------------------------------------------------------------------------------
package mls_pkg;

  localparam int MEDIAN_TAPS_DEF = 5;
  localparam int MAINT_TIMEOUT_DEF = 600000;
  localparam int DIST_W = 14;
  localparam int BATT_W = 15;
  localparam int CFG_W = 22;
  localparam int CFG_IDX_W = 3;

  localparam logic [DIST_W-1:0] DIST_RESET = 14'd9990;
  localparam logic [BATT_W-1:0] BATT_RESET = 15'd12000;
  localparam logic [11:0] LOW_VOLT_TIME = 12'd3000;
  localparam logic [7:0] POLL_FAST = 8'd50;
  localparam logic [7:0] POLL_SLOW = 8'd250;
  localparam logic [7:0] POLL_BATT = 8'd200;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_FORCE_OPEN = 2'd1,
    ACT_MAINT_START = 2'd2,
    ACT_MAINT_STOP = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_STARTUP = 4'd0,
    ST_IDLE = 4'd1,
    ST_OPEN_START = 4'd2,
    ST_OPENING = 4'd3,
    ST_HOLD = 4'd4,
    ST_CLOSE_START = 4'd5,
    ST_CLOSING = 4'd6,
    ST_MAINT = 4'd7,
    ST_LOWBAT = 4'd8
  } lid_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESENCE = 3'd0,
    CFG_DEBOUNCE = 3'd1,
    CFG_HOLD_WAIT = 3'd2,
    CFG_MAX_HOLD = 3'd3,
    CFG_ACTUATOR = 3'd4,
    CFG_COOLDOWN = 3'd5,
    CFG_LOW_VOLT = 3'd6,
    CFG_START_OPEN = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [13:0] presence_threshold;
    logic [15:0] debounce_ms;
    logic [19:0] hold_wait_ms;
    logic [21:0] max_hold_ms;
    logic [15:0] actuator_ms;
    logic [15:0] cooldown_ms;
    logic [14:0] low_volt_mv;
    logic start_open;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [13:0] raw_distance;
    logic [14:0] battery_mv;
    logic night_sleep;
  } in_item_t;

  typedef struct packed {
    logic [3:0] lid_state;
    logic main_on;
    logic dir_open;
    logic dir_close;
    logic relays_isolated;
    logic [13:0] filtered_distance;
    logic motor_running;
    logic [11:0] maintenance_seconds_left;
  } out_item_t;

endpackage

[rtl/mls_if.sv]
//------------------------------------------------------------------------------
// mls_in_if / mls_out_if
// valid/ready channels for input and result transactions
//------------------------------------------------------------------------------
interface mls_in_if;
  logic valid;
  logic ready;
  mls_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mls_out_if;
  logic valid;
  logic ready;
  mls_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/mls_cfg.sv]
//------------------------------------------------------------------------------
// mls_cfg
// configuration register file
//------------------------------------------------------------------------------
module mls_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [mls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mls_pkg::CFG_W-1:0] cfg_data,
  output mls_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.presence_threshold <= 14'd500;
      cfg.debounce_ms <= 16'd500;
      cfg.hold_wait_ms <= 20'd10000;
      cfg.max_hold_ms <= 22'd60000;
      cfg.actuator_ms <= 16'd3800;
      cfg.cooldown_ms <= 16'd2000;
      cfg.low_volt_mv <= 15'd10500;
      cfg.start_open <= 1'b0;
    end else if (cfg_we) begin
      case (mls_pkg::cfg_idx_t'(cfg_index))
        mls_pkg::CFG_PRESENCE: cfg.presence_threshold <= cfg_data[13:0];
        mls_pkg::CFG_DEBOUNCE: cfg.debounce_ms <= cfg_data[15:0];
        mls_pkg::CFG_HOLD_WAIT: cfg.hold_wait_ms <= cfg_data[19:0];
        mls_pkg::CFG_MAX_HOLD: cfg.max_hold_ms <= cfg_data[21:0];
        mls_pkg::CFG_ACTUATOR: cfg.actuator_ms <= cfg_data[15:0];
        mls_pkg::CFG_COOLDOWN: cfg.cooldown_ms <= cfg_data[15:0];
        mls_pkg::CFG_LOW_VOLT: cfg.low_volt_mv <= cfg_data[14:0];
        mls_pkg::CFG_START_OPEN: cfg.start_open <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/mls_median.sv]
//------------------------------------------------------------------------------
// mls_median
// distance sample history and median selection by rank counting
//------------------------------------------------------------------------------
module mls_median #(
  parameter int TAPS = mls_pkg::MEDIAN_TAPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic sample,
  input  logic [mls_pkg::DIST_W-1:0] raw,
  output logic [mls_pkg::DIST_W-1:0] median
);

  localparam int SLOT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CNT_W = $clog2(TAPS + 1);
  localparam int MID = TAPS / 2;

  logic [mls_pkg::DIST_W-1:0] hist [TAPS];
  logic [mls_pkg::DIST_W-1:0] cand [TAPS];
  logic [SLOT_W-1:0] slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      for (int i = 0; i < TAPS; i++) hist[i] <= mls_pkg::DIST_RESET;
    end else if (sample) begin
      hist[slot] <= raw;
      slot <= (slot == SLOT_W'(TAPS - 1)) ? '0 : slot + 1'b1;
    end
  end

  // median of the history with the new sample written in
  always_comb begin
    for (int i = 0; i < TAPS; i++)
      cand[i] = (slot == SLOT_W'(i)) ? raw : hist[i];
  end

  // element i is the median when exactly MID others rank below it (ties by index)
  always_comb begin
    logic [CNT_W-1:0] lt;
    median = cand[0];
    for (int i = TAPS - 1; i >= 0; i--) begin
      lt = '0;
      for (int j = 0; j < TAPS; j++)
        if (cand[j] < cand[i] || (cand[j] == cand[i] && j < i)) lt = lt + 1'b1;
      if (lt == CNT_W'(MID)) median = cand[i];
    end
  end

endmodule

[rtl/mls_ctrl.sv]
//------------------------------------------------------------------------------
// mls_ctrl
// timers, lid state machine and result register
//------------------------------------------------------------------------------
module mls_ctrl #(
  parameter int MEDIAN_TAPS = mls_pkg::MEDIAN_TAPS_DEF,
  parameter int MAINT_TIMEOUT_MS = mls_pkg::MAINT_TIMEOUT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  mls_pkg::cfg_t cfg,
  mls_in_if.sink in_ch,
  mls_out_if.source out_ch
);

  localparam logic [31:0] MAINT_T = 32'(MAINT_TIMEOUT_MS);

  mls_pkg::lid_state_t state, state_next;
  logic [31:0] phase_el, phase_el_next, hold_el, hold_el_next;
  logic [16:0] det_el, det_el_next, cool_el, cool_el_next;
  logic det_act, det_act_next, cool_act, cool_act_next;
  logic [11:0] lv_el, lv_el_next;
  logic lv_act, lv_act_next;
  logic [7:0] dpoll, dpoll_next, bpoll, bpoll_next;
  logic [13:0] held_dist, held_dist_next, med;
  logic [14:0] held_batt, held_batt_next;
  logic deadlock, deadlock_next, maint_pend, maint_pend_next, iso, iso_next;
  logic r_main, r_open, r_close, r_main_next, r_open_next, r_close_next;
  logic fresh;
  logic sample;
  logic accept;
  logic motor;
  logic [31:0] rem;
  logic [11:0] secs;
  mls_pkg::out_item_t res;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  mls_median #(.TAPS(MEDIAN_TAPS)) u_median (
    .clk(clk), .rst(rst), .sample(accept && sample),
    .raw(in_ch.data.raw_distance), .median(med)
  );

  always_comb begin
    logic pres;
    logic [7:0] ivl;
    state_next = state;
    if (fresh) state_next = cfg.start_open ? mls_pkg::ST_STARTUP : mls_pkg::ST_IDLE;
    phase_el_next = phase_el; hold_el_next = hold_el;
    det_el_next = det_el; det_act_next = det_act;
    cool_el_next = cool_el; cool_act_next = cool_act;
    lv_el_next = lv_el; lv_act_next = lv_act;
    dpoll_next = dpoll; bpoll_next = bpoll;
    held_dist_next = held_dist; held_batt_next = held_batt;
    deadlock_next = deadlock; maint_pend_next = maint_pend; iso_next = iso;
    r_main_next = r_main; r_open_next = r_open; r_close_next = r_close;
    sample = 1'b0;
    pres = 1'b0;
    ivl = in_ch.data.night_sleep ? mls_pkg::POLL_SLOW : mls_pkg::POLL_FAST;

    case (mls_pkg::action_t'(in_ch.data.action))
      mls_pkg::ACT_TICK: begin
        phase_el_next = (&phase_el) ? phase_el : phase_el + 1'b1;
        hold_el_next = (&hold_el) ? hold_el : hold_el + 1'b1;
        if (det_act && !(&det_el)) det_el_next = det_el + 1'b1;
        if (cool_act && !(&cool_el)) cool_el_next = cool_el + 1'b1;
        if (lv_act && !(&lv_el)) lv_el_next = lv_el + 1'b1;
        dpoll_next = (&dpoll) ? dpoll : dpoll + 1'b1;
        bpoll_next = (&bpoll) ? bpoll : bpoll + 1'b1;
        if (dpoll_next >= ivl) begin
          dpoll_next = '0;
          sample = 1'b1;
          held_dist_next = med;
        end
        if (bpoll_next >= mls_pkg::POLL_BATT) begin
          bpoll_next = '0;
          held_batt_next = in_ch.data.battery_mv;
        end
        pres = held_dist_next != '0 && held_dist_next < cfg.presence_threshold;

        if (held_batt_next < cfg.low_volt_mv && state_next != mls_pkg::ST_LOWBAT) begin
          if (!lv_act) begin
            lv_act_next = 1'b1;
            lv_el_next = '0;
          end else if (lv_el_next >= mls_pkg::LOW_VOLT_TIME) begin
            state_next = mls_pkg::ST_LOWBAT;
            phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
            r_main_next = 1'b1; r_open_next = 1'b1; r_close_next = 1'b0;
            iso_next = 1'b0;
          end
        end else begin
          lv_act_next = 1'b0;
          lv_el_next = '0;
        end

        if (cool_act_next && cool_el_next >= 17'(cfg.cooldown_ms)) begin
          cool_act_next = 1'b0;
          cool_el_next = '0;
        end

        case (state_next)
          mls_pkg::ST_STARTUP: begin
            r_main_next = 1'b0; r_open_next = 1'b0; r_close_next = 1'b0;
            if (pres && !cool_act_next) begin
              state_next = mls_pkg::ST_HOLD;
              phase_el_next = '0; hold_el_next = '0;
              det_act_next = 1'b0; det_el_next = '0;
            end
          end
          mls_pkg::ST_IDLE: begin
            r_main_next = 1'b0; r_open_next = 1'b0; r_close_next = 1'b0;
            if (held_dist_next > cfg.presence_threshold) deadlock_next = 1'b0;
            if (pres && !cool_act_next && !deadlock_next) begin
              if (!det_act_next) begin
                det_act_next = 1'b1;
                det_el_next = '0;
              end else if (det_el_next >= 17'(cfg.debounce_ms)) begin
                state_next = mls_pkg::ST_OPEN_START;
                phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
              end
            end else begin
              det_act_next = 1'b0;
              det_el_next = '0;
            end
          end
          mls_pkg::ST_OPEN_START: begin
            r_main_next = 1'b1; r_open_next = 1'b1; r_close_next = 1'b0;
            iso_next = 1'b0;
            state_next = mls_pkg::ST_OPENING;
            phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
          end
          mls_pkg::ST_OPENING: begin
            if (phase_el_next >= 32'(cfg.actuator_ms)) begin
              r_main_next = 1'b0; r_open_next = 1'b0; r_close_next = 1'b0;
              state_next = maint_pend ? mls_pkg::ST_MAINT : mls_pkg::ST_HOLD;
              if (!maint_pend) hold_el_next = '0;
              phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
            end
          end
          mls_pkg::ST_HOLD: begin
            r_main_next = 1'b0; r_open_next = 1'b0; r_close_next = 1'b0;
            if (hold_el_next >= 32'(cfg.max_hold_ms)) begin
              deadlock_next = 1'b1;
              state_next = mls_pkg::ST_CLOSE_START;
              phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
            end else begin
              if (pres) phase_el_next = '0;
              if (phase_el_next >= 32'(cfg.hold_wait_ms)) begin
                state_next = mls_pkg::ST_CLOSE_START;
                phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
              end
            end
          end
          mls_pkg::ST_CLOSE_START: begin
            r_main_next = 1'b1; r_open_next = 1'b0; r_close_next = 1'b1;
            iso_next = 1'b0;
            state_next = mls_pkg::ST_CLOSING;
            phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
          end
          mls_pkg::ST_CLOSING: begin
            if (pres && !deadlock) begin
              r_main_next = 1'b0; r_open_next = 1'b0; r_close_next = 1'b0;
              state_next = mls_pkg::ST_OPEN_START;
              phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
            end else if (phase_el_next >= 32'(cfg.actuator_ms)) begin
              r_main_next = 1'b0; r_open_next = 1'b0; r_close_next = 1'b0;
              cool_act_next = 1'b1; cool_el_next = '0;
              state_next = mls_pkg::ST_IDLE;
              phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
            end
          end
          mls_pkg::ST_MAINT: begin
            r_main_next = 1'b0; r_open_next = 1'b0; r_close_next = 1'b0;
            if (phase_el_next >= MAINT_T) begin
              maint_pend_next = 1'b0;
              state_next = mls_pkg::ST_CLOSE_START;
              phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
            end
          end
          mls_pkg::ST_LOWBAT: begin
            if (phase_el_next >= 32'(cfg.actuator_ms)) begin
              r_main_next = 1'b0; r_open_next = 1'b0; r_close_next = 1'b0;
              iso_next = 1'b1;
            end
          end
          default: begin
            state_next = mls_pkg::ST_IDLE;
            phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
          end
        endcase
      end
      mls_pkg::ACT_FORCE_OPEN: begin
        if (state_next != mls_pkg::ST_LOWBAT) begin
          state_next = mls_pkg::ST_OPEN_START;
          phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
        end
      end
      mls_pkg::ACT_MAINT_START: begin
        if (state_next != mls_pkg::ST_LOWBAT) begin
          maint_pend_next = 1'b1;
          if (state_next == mls_pkg::ST_HOLD || state_next == mls_pkg::ST_STARTUP) begin
            state_next = mls_pkg::ST_MAINT;
            phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
          end else if (state_next != mls_pkg::ST_MAINT && state_next != mls_pkg::ST_OPENING
                       && state_next != mls_pkg::ST_OPEN_START) begin
            state_next = mls_pkg::ST_OPEN_START;
            phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
          end
        end
      end
      default: begin
        maint_pend_next = 1'b0;
        if (state_next == mls_pkg::ST_MAINT) begin
          state_next = mls_pkg::ST_CLOSE_START;
          phase_el_next = '0; det_act_next = 1'b0; det_el_next = '0;
        end
      end
    endcase
  end

  // result fields from the next state
  always_comb begin
    motor = state_next == mls_pkg::ST_OPEN_START || state_next == mls_pkg::ST_OPENING ||
            state_next == mls_pkg::ST_CLOSE_START || state_next == mls_pkg::ST_CLOSING ||
            (state_next == mls_pkg::ST_LOWBAT && phase_el_next < 32'(cfg.actuator_ms));
    rem = MAINT_T - phase_el_next;
    // whole seconds by reciprocal multiply, remainder below 2^22
    secs = 12'((64'(rem) * 64'd4294968) >> 32);
    if (!(state_next == mls_pkg::ST_MAINT && phase_el_next < MAINT_T)) secs = '0;
    res.lid_state = state_next;
    res.main_on = r_main_next;
    res.dir_open = r_open_next;
    res.dir_close = r_close_next;
    res.relays_isolated = iso_next;
    res.filtered_distance = held_dist_next;
    res.motor_running = motor;
    res.maintenance_seconds_left = secs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mls_pkg::ST_IDLE;
      fresh <= 1'b1;
      phase_el <= '0; hold_el <= '0;
      det_el <= '0; det_act <= 1'b0; cool_el <= '0; cool_act <= 1'b0;
      lv_el <= '0; lv_act <= 1'b0; dpoll <= '0; bpoll <= '0;
      held_dist <= mls_pkg::DIST_RESET; held_batt <= mls_pkg::BATT_RESET;
      deadlock <= 1'b0; maint_pend <= 1'b0; iso <= 1'b0;
      r_main <= 1'b0; r_open <= 1'b0; r_close <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (accept) begin
        fresh <= 1'b0;
        state <= state_next;
        phase_el <= phase_el_next; hold_el <= hold_el_next;
        det_el <= det_el_next; det_act <= det_act_next;
        cool_el <= cool_el_next; cool_act <= cool_act_next;
        lv_el <= lv_el_next; lv_act <= lv_act_next;
        dpoll <= dpoll_next; bpoll <= bpoll_next;
        held_dist <= held_dist_next; held_batt <= held_batt_next;
        deadlock <= deadlock_next; maint_pend <= maint_pend_next; iso <= iso_next;
        r_main <= r_main_next; r_open <= r_open_next; r_close <= r_close_next;
        out_ch.data <= res;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  a_iso_relays_off: assert property (@(posedge clk) disable iff (rst)
    iso |-> !r_main && !r_open && !r_close) else $error("isolated with relay on");
  a_lowbat_sticky: assert property (@(posedge clk) disable iff (rst)
    state == mls_pkg::ST_LOWBAT |=> state == mls_pkg::ST_LOWBAT)
    else $error("left low battery");
  a_dir_excl: assert property (@(posedge clk) disable iff (rst)
    !(r_open && r_close)) else $error("both directions");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result lost under stall");

endmodule

[rtl/motorized_lid_sequencer_core.sv]
//------------------------------------------------------------------------------
// motorized_lid_sequencer_core
// lid sequencer with distance median filter, battery guard and relay drive
//------------------------------------------------------------------------------
// in_ch carries one transaction per ms tick or command (action, raw distance,
// battery, night sleep). out_ch returns exactly one result transaction for
// each input transaction: lid state, relay drives, filtered distance, motor
// and maintenance seconds left.
// the result is registered and valid in the cycle after the input is accepted.
// throughput: one transaction per cycle while out_ch is not stalled, set by
// the single registered pass through the median network and state machine.
// in_ch.ready is high while the output register is empty or being taken;
// when the receiver stalls the result holds and the input stalls with it.
// configuration is written through cfg_we/cfg_index/cfg_data only while idle,
// the user's duty, not enforced by the block. reset (rst, synchronous)
// restores register defaults, fills the median history with 9990 and picks
// startup-open or idle at the first transaction from the start_open register.
//------------------------------------------------------------------------------
module motorized_lid_sequencer_core #(
  parameter int MEDIAN_TAPS = mls_pkg::MEDIAN_TAPS_DEF,
  parameter int MAINT_TIMEOUT_MS = mls_pkg::MAINT_TIMEOUT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [mls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mls_pkg::CFG_W-1:0] cfg_data,
  mls_in_if.sink in_ch,
  mls_out_if.source out_ch
);

  mls_pkg::cfg_t cfg;

  mls_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  mls_ctrl #(.MEDIAN_TAPS(MEDIAN_TAPS), .MAINT_TIMEOUT_MS(MAINT_TIMEOUT_MS)) u_ctrl (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
  );

endmodule
